FILE: src/pfa2_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa2_pkg
// Shared constants and types for the two-objective pareto archive.
// ----------------------------------------------------------------------------
package pfa2_pkg;

    localparam int DEF_ARCHIVE_DEPTH = 64;
    localparam int DEF_VALUE_WIDTH   = 40;

    localparam int OUT_CNT_W = 7;
    localparam int RES_W     = 16;
    localparam int GRP_SIZE  = 8;
    localparam int GRP_CW    = 4;

    typedef struct packed {
        logic                 overflow;
        logic [OUT_CNT_W-1:0] entry_count;
        logic [OUT_CNT_W-1:0] removed_count;
        logic                 accepted;
    } t_result;

endpackage

FILE: src/pfa2_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa2_front
// Accepts candidate words and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module pfa2_front
    import pfa2_pkg::*;
#(
    parameter int DATA_W = 2 * DEF_VALUE_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_valid,
    output logic              o_s_ready,
    input  logic [DATA_W-1:0] i_s_data,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output logic [DATA_W-1:0] o_q_data
);

    logic [DATA_W-1:0] r_mem [2];
    logic [1:0]        r_cnt;
    logic              r_wr;
    logic              r_rd;
    logic              w_push;
    logic              w_pop;

    assign o_s_ready = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_mem[r_rd];
    assign w_push    = i_s_valid && o_s_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_s_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

FILE: src/pfa2_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfa2_back
// Archive entries with parallel dominance compare, then removal and append.
// ----------------------------------------------------------------------------
module pfa2_back
    import pfa2_pkg::*;
#(
    parameter int ARCHIVE_DEPTH = DEF_ARCHIVE_DEPTH,
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cand_valid,
    output logic                   o_cand_ready,
    input  logic [VALUE_WIDTH-1:0] i_cand_cost,
    input  logic [VALUE_WIDTH-1:0] i_cand_load,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output t_result                o_res
);

    localparam int CNT_W  = $clog2(ARCHIVE_DEPTH + 1);
    localparam int GROUPS = (ARCHIVE_DEPTH + GRP_SIZE - 1) / GRP_SIZE;
    localparam int ACC_W  = CNT_W + GRP_CW;

    localparam logic S_CMP = 1'b0;
    localparam logic S_UPD = 1'b1;

    logic                     r_state;
    logic [VALUE_WIDTH-1:0]   r_cost [ARCHIVE_DEPTH];
    logic [VALUE_WIDTH-1:0]   r_load [ARCHIVE_DEPTH];
    logic [ARCHIVE_DEPTH-1:0] r_valid;
    logic [CNT_W-1:0]         r_total;
    logic [ARCHIVE_DEPTH-1:0] r_rem;
    logic                     r_dom;
    logic [GRP_CW-1:0]        r_grp [GROUPS];
    logic [VALUE_WIDTH-1:0]   r_cand_cost;
    logic [VALUE_WIDTH-1:0]   r_cand_load;
    logic                     r_res_valid;
    t_result                  r_res;

    logic [ARCHIVE_DEPTH-1:0] n_rem;
    logic [ARCHIVE_DEPTH-1:0] w_dom_vec;
    logic [GRP_CW-1:0]        n_grp [GROUPS];
    logic                     w_take;
    logic                     w_commit;
    logic [ARCHIVE_DEPTH-1:0] w_occ;
    logic [ARCHIVE_DEPTH-1:0] w_free;
    logic [ARCHIVE_DEPTH-1:0] w_wr_oh;
    logic [ACC_W-1:0]         w_rem_sum;
    logic [CNT_W-1:0]         w_removed;
    logic [CNT_W-1:0]         w_kept;
    logic                     w_add;
    logic [CNT_W-1:0]         n_total;

    // per-entry compare against the queue head
    always_comb begin
        for (int i = 0; i < ARCHIVE_DEPTH; i++) begin
            n_rem[i] = r_valid[i] && (i_cand_cost <= r_cost[i])
                       && (i_cand_load <= r_load[i]);
            w_dom_vec[i] = r_valid[i] && !n_rem[i] && (r_cost[i] <= i_cand_cost)
                           && (r_load[i] <= i_cand_load);
        end
    end

    // removal counts per group of eight entries
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SIZE; j++) begin
                if (g * GRP_SIZE + j < ARCHIVE_DEPTH) begin
                    n_grp[g] = n_grp[g] + GRP_CW'(n_rem[g * GRP_SIZE + j]);
                end
            end
        end
    end

    assign w_take       = (r_state == S_CMP) && i_cand_valid;
    assign o_cand_ready = (r_state == S_CMP);
    assign w_commit     = (r_state == S_UPD) && (!r_res_valid || i_res_ready);

    // update: drop removed entries, place a non-dominated candidate in the lowest free slot if there is room
    always_comb begin
        w_rem_sum = '0;
        for (int g = 0; g < GROUPS; g++) begin
            w_rem_sum = w_rem_sum + ACC_W'(r_grp[g]);
        end
    end

    assign w_removed = w_rem_sum[CNT_W-1:0];
    assign w_kept    = r_total - w_removed;
    assign w_occ     = r_valid & ~r_rem;
    assign w_free    = ~w_occ;
    assign w_wr_oh   = w_free & (~w_free + {{(ARCHIVE_DEPTH-1){1'b0}}, 1'b1});
    assign w_add     = !r_dom && (w_kept < CNT_W'(ARCHIVE_DEPTH));
    assign n_total   = w_add ? (w_kept + {{(CNT_W-1){1'b0}}, 1'b1}) : w_kept;

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rem       <= n_rem;
            r_dom       <= |w_dom_vec;
            r_grp       <= n_grp;
            r_cand_cost <= i_cand_cost;
            r_cand_load <= i_cand_load;
        end
        for (int i = 0; i < ARCHIVE_DEPTH; i++) begin
            if (w_commit && w_add && w_wr_oh[i]) begin
                r_cost[i] <= r_cand_cost;
                r_load[i] <= r_cand_load;
            end
        end
        if (w_commit) begin
            r_res.accepted      <= w_add;
            r_res.overflow      <= !r_dom && !w_add;
            r_res.removed_count <= OUT_CNT_W'(w_removed);
            r_res.entry_count   <= OUT_CNT_W'(n_total);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CMP;
            r_valid     <= '0;
            r_total     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_CMP: begin
                    if (w_take) begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (w_commit) begin
                        r_state <= S_CMP;
                    end
                end
                default: begin
                    r_state <= S_CMP;
                end
            endcase
            if (w_commit) begin
                r_valid     <= w_add ? (w_occ | w_wr_oh) : w_occ;
                r_total     <= n_total;
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    a_total_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_total))
        else $error("entry count out of step with valid bits");

    a_total_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_total) <= ARCHIVE_DEPTH)
        else $error("entry count above archive depth");

    a_acc_ovf_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> !(r_res.accepted && r_res.overflow))
        else $error("result both accepted and overflowed");

    a_accept_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_add) |=> (r_valid != '0))
        else $error("accepted candidate missing from archive");

endmodule

FILE: src/pareto_front_archive_2d.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pareto_front_archive_2d
// Bounded archive of non-dominated (cost, load) points, one result per word.
// ----------------------------------------------------------------------------
// each candidate passes through two engine states: the compare state checks it
// against every archive entry in parallel and counts removals, the update state
// clears removed entries and, unless the candidate is dominated or the archive
// is full, writes it into the lowest free slot. a two-entry input queue and a
// result register let input and output stall on their own. the engine takes no
// new word before the last update commits. the archive is empty straight after
// reset; no clearing pass is needed. entry order inside the archive is not kept
// and has no effect on results.
module pareto_front_archive_2d
    import pfa2_pkg::*;
#(
    parameter int ARCHIVE_DEPTH = DEF_ARCHIVE_DEPTH,
    parameter int VALUE_WIDTH   = DEF_VALUE_WIDTH,
    localparam int IN_W = ((2 * VALUE_WIDTH + 7) / 8) * 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [IN_W-1:0] s_axis_tdata,   // cand_cost, cand_load
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [RES_W-1:0] m_axis_tdata   // accepted, removed_count, entry_count, overflow
);

    logic                       w_q_valid;
    logic                       w_q_ready;
    logic [2*VALUE_WIDTH-1:0]   w_q_data;
    t_result                    w_res;

    pfa2_front #(
        .DATA_W (2 * VALUE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .i_s_data  (s_axis_tdata[2*VALUE_WIDTH-1:0]),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_data  (w_q_data)
    );

    pfa2_back #(
        .ARCHIVE_DEPTH (ARCHIVE_DEPTH),
        .VALUE_WIDTH   (VALUE_WIDTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cand_valid (w_q_valid),
        .o_cand_ready (w_q_ready),
        .i_cand_cost  (w_q_data[VALUE_WIDTH-1:0]),
        .i_cand_load  (w_q_data[2*VALUE_WIDTH-1:VALUE_WIDTH]),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (w_res)
    );

    assign m_axis_tdata = w_res;

endmodule
